// ===== design/fsrm_pkg.sv =====
package fsrm_pkg;

   // Width of a slot number on the request and response channels.
   localparam int unsigned SLOT_W = 6;
   localparam int unsigned REV_W  = 64;

   typedef enum logic [1:0] {
      CMD_ACQUIRE  = 2'd0,
      CMD_SUBMIT   = 2'd1,
      CMD_COMPLETE = 2'd2,
      CMD_CONSUME  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      PH_AVAILABLE = 2'd0,
      PH_RECORDING = 2'd1,
      PH_SUBMITTED = 2'd2,
      PH_READY     = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      STS_DONE  = 2'd0,
      STS_NONE  = 2'd1,
      STS_ERROR = 2'd2
   } status_type;

   // Verdict of the slot test unit for the slot under examination.
   typedef struct packed {
      logic      hit;
      phase_type next_phase;
   } test_type;

endpackage

// ===== design/fsrm_tag_ram.sv =====
module fsrm_tag_ram #(
   parameter int unsigned DEPTH  = 4,
   parameter int unsigned ADDR_W = 2
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  logic [fsrm_pkg::REV_W-1:0]  wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output logic [fsrm_pkg::REV_W-1:0]  rd_data
);

   logic [fsrm_pkg::REV_W-1:0] mem [DEPTH];
   logic [fsrm_pkg::REV_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/fsrm_slot_test.sv =====
module fsrm_slot_test (
   input  fsrm_pkg::cmd_type             command,
   input  fsrm_pkg::phase_type           phase,
   input  logic [fsrm_pkg::REV_W-1:0]    tag,
   input  logic [fsrm_pkg::REV_W-1:0]    revision,
   output fsrm_pkg::test_type            verdict
);

   // Each command looks for one phase (consume also a matching tag) and moves the slot to the next one.
   always_comb begin
      verdict.hit        = 1'b0;
      verdict.next_phase = phase;
      unique case (command)
         fsrm_pkg::CMD_ACQUIRE: begin
            verdict.hit        = (phase == fsrm_pkg::PH_AVAILABLE);
            verdict.next_phase = fsrm_pkg::PH_RECORDING;
         end
         fsrm_pkg::CMD_SUBMIT: begin
            verdict.hit        = (phase == fsrm_pkg::PH_RECORDING);
            verdict.next_phase = fsrm_pkg::PH_SUBMITTED;
         end
         fsrm_pkg::CMD_COMPLETE: begin
            verdict.hit        = (phase == fsrm_pkg::PH_SUBMITTED);
            verdict.next_phase = fsrm_pkg::PH_READY;
         end
         fsrm_pkg::CMD_CONSUME: begin
            verdict.hit        = (phase == fsrm_pkg::PH_READY) && (tag == revision);
            verdict.next_phase = fsrm_pkg::PH_AVAILABLE;
         end
         default: begin
            verdict.hit        = 1'b0;
            verdict.next_phase = phase;
         end
      endcase
   end

endmodule

// ===== design/frame_slot_ring_manager_unit.sv =====
// Channel   Direction  Contents
// req_*     in         one request: command, slot, revision
// rsp_*     out        one response per request: status, slot_index
//
// A request passes through the sequencer states in order: idle, where it is taken, a tag read and
// a slot test per slot examined, and finish. Submit and complete examine one slot, an acquire or
// consume scan up to SLOT_COUNT; an out-of-range submit or complete goes from idle to finish.
// req_tready is high only while the sequencer is idle. A finished response waits in an output
// register, so the next request is taken while rsp_tready holds that one back.
// Reset is synchronous and frees all slots. Tags are not cleared: a tag is only compared on a
// ready slot, which an acquire has always written first.
module frame_slot_ring_manager_unit #(
   parameter int unsigned SLOT_COUNT = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // [1:0] command, [7:2] slot, [71:8] revision
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata    // [1:0] status, [7:2] slot_index
);

   localparam int unsigned IDX_W = $clog2(SLOT_COUNT);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_TEST   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type                   state_ff, state_in;
   fsrm_pkg::cmd_type           cmd_ff, cmd_in;
   logic [fsrm_pkg::REV_W-1:0]  rev_ff, rev_in;
   logic [IDX_W-1:0]            idx_ff, idx_in;
   fsrm_pkg::phase_type         phase_ff [SLOT_COUNT];
   fsrm_pkg::phase_type         phase_in [SLOT_COUNT];
   fsrm_pkg::status_type        sts_ff, sts_in;
   logic [fsrm_pkg::SLOT_W-1:0] res_idx_ff, res_idx_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_data_ff, rsp_data_in;

   fsrm_pkg::cmd_type           req_cmd;
   logic [fsrm_pkg::SLOT_W-1:0] req_slot;
   logic                        req_fire;
   logic                        req_in_range;
   logic                        is_scan;
   logic                        last_idx;
   logic                        tag_we;
   logic                        tag_re;
   logic [fsrm_pkg::REV_W-1:0]  tag_rd;
   fsrm_pkg::test_type          verdict;

   assign req_cmd      = fsrm_pkg::cmd_type'(req_tdata[1:0]);
   assign req_slot     = req_tdata[7:2];
   assign req_tready   = (state_ff == ST_IDLE);
   assign req_fire     = req_tvalid && req_tready;
   assign req_in_range = ({1'b0, req_slot} < 7'(SLOT_COUNT));
   assign is_scan      = (cmd_ff == fsrm_pkg::CMD_ACQUIRE) || (cmd_ff == fsrm_pkg::CMD_CONSUME);
   assign last_idx     = (idx_ff == IDX_W'(SLOT_COUNT - 1));
   assign tag_re       = (state_ff == ST_READ);
   assign tag_we       = (state_ff == ST_TEST) && verdict.hit
                         && (cmd_ff == fsrm_pkg::CMD_ACQUIRE);

   fsrm_tag_ram #(
      .DEPTH  (SLOT_COUNT),
      .ADDR_W (IDX_W)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (tag_we),
      .wr_addr (idx_ff),
      .wr_data (rev_ff),
      .rd_en   (tag_re),
      .rd_addr (idx_ff),
      .rd_data (tag_rd)
   );

   fsrm_slot_test u_slot_test (
      .command  (cmd_ff),
      .phase    (phase_ff[idx_ff]),
      .tag      (tag_rd),
      .revision (rev_ff),
      .verdict  (verdict)
   );

   // Sequencer: load the request, then read and test one slot per pass.
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      rev_in       = rev_ff;
      idx_in       = idx_ff;
      phase_in     = phase_ff;
      sts_in       = sts_ff;
      res_idx_in   = res_idx_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in     = req_cmd;
               rev_in     = req_tdata[71:8];
               res_idx_in = '0;
               if ((req_cmd == fsrm_pkg::CMD_ACQUIRE) || (req_cmd == fsrm_pkg::CMD_CONSUME)) begin
                  idx_in   = '0;
                  state_in = ST_READ;
               end else if (req_in_range) begin
                  idx_in   = req_slot[IDX_W-1:0];
                  state_in = ST_READ;
               end else begin
                  // Slot number beyond the ring: reject without looking.
                  sts_in   = fsrm_pkg::STS_ERROR;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_READ: begin
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (verdict.hit) begin
               phase_in[idx_ff] = verdict.next_phase;
               sts_in           = fsrm_pkg::STS_DONE;
               res_idx_in       = is_scan ? fsrm_pkg::SLOT_W'(idx_ff) : '0;
               state_in         = ST_FINISH;
            end else if (is_scan && !last_idx) begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_READ;
            end else begin
               sts_in   = is_scan ? fsrm_pkg::STS_NONE : fsrm_pkg::STS_ERROR;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hand the result over once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {res_idx_ff, sts_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            phase_ff[i] <= fsrm_pkg::PH_AVAILABLE;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      rev_ff      <= rev_in;
      idx_ff      <= idx_in;
      sts_ff      <= sts_in;
      res_idx_ff  <= res_idx_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff != ST_IDLE))
      else $error("sequencer stayed idle after taking a request");

   a_test_after_read: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TEST) |-> ($past(state_ff) == ST_READ))
      else $error("slot tested without a tag read");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[1:0] != 2'd3))
      else $error("undefined status code on the response");

   a_index_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tdata[1:0] != fsrm_pkg::STS_DONE)) |-> (rsp_tdata[7:2] == '0))
      else $error("failed response carries a slot index");
`endif

endmodule

// ===== sim/frame_slot_ring_manager_unit_tb.sv =====
`timescale 1ns / 100ps

module frame_slot_ring_manager_unit_tb;

   localparam int unsigned SLOTS = 4;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int RANDOM_BATCH = 300;

   // Request as it travels on req_tdata: command in the low bits, revision on top.
   typedef struct packed {
      logic [fsrm_pkg::REV_W-1:0]  revision;
      logic [fsrm_pkg::SLOT_W-1:0] slot;
      fsrm_pkg::cmd_type           command;
   } request_type;

   // Response as it travels on rsp_tdata: status in the low bits.
   typedef struct packed {
      logic [fsrm_pkg::SLOT_W-1:0] slot_index;
      fsrm_pkg::status_type        status;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;   // [1:0] command, [7:2] slot, [71:8] revision
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // [1:0] status, [7:2] slot_index

   frame_slot_ring_manager_unit #(
      .SLOT_COUNT(SLOTS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   request_type  pending_requests[$];
   response_type awaited_responses[$];

   // Predicted contents of the slot ring.
   fsrm_pkg::phase_type        ring_phase[SLOTS];
   logic [fsrm_pkg::REV_W-1:0] ring_tag[SLOTS];

   int idle_pct = 0;
   int stall_pct = 0;
   int hold_asked = 0;
   int hold_served = 0;
   int hold_left = 0;
   int error_count = 0;
   int quiet_cycles = 0;
   logic req_taken = 1'b0;
   logic [fsrm_pkg::REV_W-1:0] tag_pool[4];
   response_type want_rsp;
   response_type got_rsp;

   // Submit and complete share this: move one slot forward if it sits in the right phase.
   function automatic fsrm_pkg::status_type move_slot(logic [fsrm_pkg::SLOT_W-1:0] slot,
                                                      fsrm_pkg::phase_type from_phase,
                                                      fsrm_pkg::phase_type to_phase);
      if (slot >= SLOTS || ring_phase[slot] != from_phase)
         return fsrm_pkg::STS_ERROR;
      ring_phase[slot] = to_phase;
      return fsrm_pkg::STS_DONE;
   endfunction

   function automatic response_type predict_response(request_type rq);
      response_type rs;
      bit found;
      rs.status = fsrm_pkg::STS_NONE;
      rs.slot_index = '0;
      found = 1'b0;
      case (rq.command)
         fsrm_pkg::CMD_ACQUIRE: begin
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && ring_phase[i] == fsrm_pkg::PH_AVAILABLE) begin
                  ring_phase[i] = fsrm_pkg::PH_RECORDING;
                  ring_tag[i] = rq.revision;
                  rs.status = fsrm_pkg::STS_DONE;
                  rs.slot_index = fsrm_pkg::SLOT_W'(i);
                  found = 1'b1;
               end
            end
         end
         fsrm_pkg::CMD_SUBMIT:
            rs.status = move_slot(rq.slot, fsrm_pkg::PH_RECORDING, fsrm_pkg::PH_SUBMITTED);
         fsrm_pkg::CMD_COMPLETE:
            rs.status = move_slot(rq.slot, fsrm_pkg::PH_SUBMITTED, fsrm_pkg::PH_READY);
         default: begin
            // Consume ready: lowest ready slot whose tag matches; the tag stays behind.
            for (int i = 0; i < SLOTS; i++) begin
               if (!found && ring_phase[i] == fsrm_pkg::PH_READY
                   && ring_tag[i] == rq.revision) begin
                  ring_phase[i] = fsrm_pkg::PH_AVAILABLE;
                  rs.status = fsrm_pkg::STS_DONE;
                  rs.slot_index = fsrm_pkg::SLOT_W'(i);
                  found = 1'b1;
               end
            end
         end
      endcase
      return rs;
   endfunction

   // Request driver: a request stays on the bus until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
      end else if (!req_tvalid || req_taken) begin
         if (pending_requests.size() > 0 && $urandom_range(99) >= idle_pct) begin
            req_tdata <= pending_requests.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response sink: random stalls, plus a long hold-off when one is asked for.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_asked != hold_served) begin
         hold_served <= hold_asked;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Monitor: predict on every accepted request, check every accepted response.
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            ring_phase[i] = fsrm_pkg::PH_AVAILABLE;
            ring_tag[i] = '0;
         end
      end else begin
         req_taken <= req_tvalid && req_tready;
         if (req_tvalid && req_tready)
            awaited_responses = {awaited_responses,
                                 predict_response(request_type'(req_tdata))};
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = rsp_tdata;
            if (awaited_responses.size() == 0) begin
               error_count++;
               $display("%0t: unexpected response, expected none, got status %0d slot %0d",
                        $time, got_rsp.status, got_rsp.slot_index);
            end else begin
               want_rsp = awaited_responses.pop_front();
               if (got_rsp.status !== want_rsp.status) begin
                  error_count++;
                  $display("%0t: status mismatch, expected %0d, got %0d",
                           $time, want_rsp.status, got_rsp.status);
               end
               if (got_rsp.slot_index !== want_rsp.slot_index) begin
                  error_count++;
                  $display("%0t: slot_index mismatch, expected %0d, got %0d",
                           $time, want_rsp.slot_index, got_rsp.slot_index);
               end
            end
         end
      end
   end

   // Watchdog on cycles without any handshake.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   task automatic add_request(fsrm_pkg::cmd_type command, int slot,
                              logic [fsrm_pkg::REV_W-1:0] revision);
      request_type rq;
      rq.command = command;
      rq.slot = fsrm_pkg::SLOT_W'(slot);
      rq.revision = revision;
      pending_requests = {pending_requests, rq};
   endtask

   task automatic wait_until_drained();
      while (pending_requests.size() != 0 || req_tvalid || awaited_responses.size() != 0)
         @(posedge clock);
   endtask

   // Random traffic: tags mostly from a small pool so that consume finds ready slots,
   // slot numbers mostly in range so that frames move through their whole life.
   task automatic run_random_batch(int send_idle, int recv_stall, bit long_hold);
      int pick;
      int slot;
      logic [fsrm_pkg::REV_W-1:0] revision;
      idle_pct = send_idle;
      stall_pct = recv_stall;
      if (long_hold)
         hold_asked++;
      for (int n = 0; n < RANDOM_BATCH; n++) begin
         pick = $urandom_range(99);
         slot = ($urandom_range(99) < 85) ? $urandom_range(SLOTS - 1) : $urandom_range(63);
         revision = ($urandom_range(99) < 85) ? tag_pool[$urandom_range(3)]
                                              : {$urandom, $urandom};
         if (pick < 30)
            add_request(fsrm_pkg::CMD_ACQUIRE, slot, revision);
         else if (pick < 55)
            add_request(fsrm_pkg::CMD_SUBMIT, slot, revision);
         else if (pick < 80)
            add_request(fsrm_pkg::CMD_COMPLETE, slot, revision);
         else
            add_request(fsrm_pkg::CMD_CONSUME, slot, revision);
      end
      wait_until_drained();
   endtask

   initial begin
      tag_pool[0] = '1;
      tag_pool[1] = {$urandom, $urandom};
      tag_pool[2] = {$urandom, $urandom};
      tag_pool[3] = '0;

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty ring, range and phase errors, full ring, whole lifecycle.
      add_request(fsrm_pkg::CMD_CONSUME, 0, '0);
      add_request(fsrm_pkg::CMD_SUBMIT, 0, '1);
      add_request(fsrm_pkg::CMD_COMPLETE, 63, '0);
      add_request(fsrm_pkg::CMD_SUBMIT, SLOTS, '0);
      add_request(fsrm_pkg::CMD_ACQUIRE, 63, '1);
      add_request(fsrm_pkg::CMD_ACQUIRE, 0, '0);
      add_request(fsrm_pkg::CMD_ACQUIRE, 0, 64'h8000_0000_0000_0000);
      add_request(fsrm_pkg::CMD_ACQUIRE, 0, 64'h5555_5555_AAAA_AAAA);
      add_request(fsrm_pkg::CMD_ACQUIRE, 0, 64'h0000_0000_0000_0001);   // ring full
      add_request(fsrm_pkg::CMD_COMPLETE, 0, '0);                       // still recording
      for (int i = 0; i < SLOTS; i++)
         add_request(fsrm_pkg::CMD_SUBMIT, i, '0);
      add_request(fsrm_pkg::CMD_SUBMIT, 0, '0);                         // already submitted
      for (int i = 0; i < SLOTS; i++)
         add_request(fsrm_pkg::CMD_COMPLETE, i, '1);
      add_request(fsrm_pkg::CMD_CONSUME, 0, 64'h1234_5678_9ABC_DEF0);   // no tag matches
      add_request(fsrm_pkg::CMD_CONSUME, 0, '1);
      add_request(fsrm_pkg::CMD_CONSUME, 0, '0);
      add_request(fsrm_pkg::CMD_CONSUME, 0, '0);            // freed slot keeps its tag
      add_request(fsrm_pkg::CMD_ACQUIRE, 0, 64'h0123_4567_89AB_CDEF);   // reuses slot 0
      add_request(fsrm_pkg::CMD_CONSUME, 0, '1);            // old tag was overwritten
      add_request(fsrm_pkg::CMD_CONSUME, 63, 64'h8000_0000_0000_0000);
      add_request(fsrm_pkg::CMD_CONSUME, 0, 64'h5555_5555_AAAA_AAAA);
      wait_until_drained();

      // Random phases; the first one also holds the response side off for a while.
      run_random_batch(0, 0, 1'b1);
      run_random_batch(80, 0, 1'b0);
      run_random_batch(0, 80, 1'b0);
      run_random_batch(12, 12, 1'b0);

      repeat (40) @(posedge clock);
      if (error_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== frame_slot_ring_manager_unit.f =====
design/fsrm_pkg.sv
design/fsrm_tag_ram.sv
design/fsrm_slot_test.sv
design/frame_slot_ring_manager_unit.sv
sim/frame_slot_ring_manager_unit_tb.sv
